// ===== sv/rv32im_instruction_step_core_defines.svh =====
// ----------------------------------------------------------------------------
// RV32IM step core assertion macros
// Shared property forms for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef RV32IM_INSTRUCTION_STEP_CORE_DEFINES_SVH
`define RV32IM_INSTRUCTION_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define RVSTEP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rvstep implication check failed");

// next-cycle implication
`define RVSTEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rvstep next-cycle check failed");

`endif

// ===== sv/rvstep_pkg.sv =====
// ----------------------------------------------------------------------------
// RV32IM step core package
// Shared sizes, codes, request struct and range check.
// ----------------------------------------------------------------------------
package rvstep_pkg;

    localparam int          RAM_WORDS  = 65536;
    localparam int          RAM_AW     = $clog2(RAM_WORDS);
    localparam logic [31:0] RAM_BYTES  = 32'(RAM_WORDS * 4);
    localparam logic [31:0] RESET_BASE = 32'h8000_0000;

    localparam logic [2:0] ST_EXEC     = 3'd0;
    localparam logic [2:0] ST_MISALIGN = 3'd1;
    localparam logic [2:0] ST_FETCH    = 3'd2;
    localparam logic [2:0] ST_ILLEGAL  = 3'd3;
    localparam logic [2:0] ST_ECALL    = 3'd4;
    localparam logic [2:0] ST_LOADED   = 3'd5;
    localparam logic [2:0] ST_HALTED   = 3'd6;

    localparam logic [1:0] OPS_LOAD = 2'd0;
    localparam logic [1:0] OPS_EXEC = 2'd1;
    localparam logic [1:0] OPS_RET  = 2'd2;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] F7_ALT     = 7'h20;
    localparam logic [6:0] F7_MULDIV  = 7'h01;
    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

    localparam logic [4:0] REG_SP = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd10;
    localparam logic [4:0] REG_A1 = 5'd11;
    localparam logic [4:0] REG_A2 = 5'd12;
    localparam logic [4:0] REG_A7 = 5'd17;

    typedef struct packed {
        logic        start;
        logic [2:0]  funct3;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    function automatic logic f_in_ram(input logic [31:0] off, input logic [2:0] n);
        return (off < RAM_BYTES) && ((RAM_BYTES - off) >= {29'd0, n});
    endfunction

endpackage

// ===== sv/rvstep_ram.sv =====
// ----------------------------------------------------------------------------
// RV32IM step core RAM
// Word-wide single-port synchronous RAM with byte write enables.
// ----------------------------------------------------------------------------
module rvstep_ram (
    input  logic                          i_clk,
    input  logic [rvstep_pkg::RAM_AW-1:0] i_addr,
    input  logic                          i_we,
    input  logic [3:0]                    i_be,
    input  logic [31:0]                   i_wdata,
    output logic [31:0]                   o_rdata
);
    logic [31:0] r_mem [rvstep_pkg::RAM_WORDS];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (i_we && i_be[k]) begin
                r_mem[i_addr][8*k +: 8] <= i_wdata[8*k +: 8];
            end
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/rvstep_rf.sv =====
// ----------------------------------------------------------------------------
// RV32IM step core register file
// 32x32 two-read one-write memory; unwritten entries read as reset values.
// ----------------------------------------------------------------------------
module rvstep_rf (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_ram_end,
    input  logic        i_clr_sp,
    input  logic [4:0]  i_raddr_a,
    input  logic [4:0]  i_raddr_b,
    output logic [31:0] o_rdata_a,
    output logic [31:0] o_rdata_b,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [31:0] i_wdata
);
    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_da;
    logic [31:0] r_db;
    logic        r_va;
    logic        r_vb;
    logic [4:0]  r_aa;
    logic [4:0]  r_ab;
    logic        n_wr;

    assign n_wr = i_we && (i_waddr != 5'd0);

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_da <= r_mem[i_raddr_a];
        r_db <= r_mem[i_raddr_b];
        r_va <= r_vld[i_raddr_a];
        r_vb <= r_vld[i_raddr_b];
        r_aa <= i_raddr_a;
        r_ab <= i_raddr_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_clr_sp) begin
                r_vld[REG_SP_IDX] <= 1'b0;
            end
            if (n_wr) begin
                r_vld[i_waddr] <= 1'b1;
            end
        end
    end

    localparam int REG_SP_IDX = 2;

    assign o_rdata_a = r_va ? r_da : ((r_aa == rvstep_pkg::REG_SP) ? i_ram_end : 32'd0);
    assign o_rdata_b = r_vb ? r_db : ((r_ab == rvstep_pkg::REG_SP) ? i_ram_end : 32'd0);
endmodule

// ===== sv/rvstep_md.sv =====
// ----------------------------------------------------------------------------
// RV32IM step core multiply/divide unit
// Registered multiplier and 32-step restoring divider for the M extension.
// ----------------------------------------------------------------------------
module rvstep_md (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rvstep_pkg::t_md_req i_req,
    output logic                o_done,
    output logic [31:0]         o_result
);
    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_FIN} t_md_state;

    t_md_state   r_state;
    logic        r_done;
    logic [31:0] r_result;
    logic [2:0]  r_f3;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_negq;
    logic        r_negr;

    logic               n_sa;
    logic               n_sb;
    logic signed [65:0] n_prod;
    logic [32:0]        n_sh;
    logic [32:0]        n_diff;
    logic               n_bit;
    logic [31:0]        n_rem;
    logic               n_sgn;
    logic               n_nega;
    logic               n_negb;

    always_comb begin
        n_sa   = (r_f3 == 3'd1) || (r_f3 == 3'd2);
        n_sb   = (r_f3 == 3'd1);
        n_prod = $signed({n_sa & r_a[31], r_a}) * $signed({n_sb & r_b[31], r_b});
        n_sh   = {r_rem, r_quo[31]};
        n_diff = n_sh - {1'b0, r_div};
        n_bit  = !n_diff[32];
        n_rem  = n_bit ? n_diff[31:0] : n_sh[31:0];
        n_sgn  = !i_req.funct3[0];
        n_nega = n_sgn && i_req.a[31];
        n_negb = n_sgn && i_req.b[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                MD_IDLE: begin
                    if (i_req.start) begin
                        r_f3 <= i_req.funct3;
                        r_a  <= i_req.a;
                        r_b  <= i_req.b;
                        if (!i_req.funct3[2]) begin
                            r_state <= MD_MUL;
                        end else if (i_req.b == 32'd0) begin
                            r_result <= i_req.funct3[1] ? i_req.a : 32'hFFFF_FFFF;
                            r_done   <= 1'b1;
                        end else begin
                            r_negq  <= n_nega ^ n_negb;
                            r_negr  <= n_nega;
                            r_quo   <= n_nega ? (32'd0 - i_req.a) : i_req.a;
                            r_div   <= n_negb ? (32'd0 - i_req.b) : i_req.b;
                            r_rem   <= 32'd0;
                            r_cnt   <= 5'd0;
                            r_state <= MD_DIV;
                        end
                    end
                end
                MD_MUL: begin
                    r_result <= (r_f3 == 3'd0) ? n_prod[31:0] : n_prod[63:32];
                    r_done   <= 1'b1;
                    r_state  <= MD_IDLE;
                end
                MD_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[30:0], n_bit};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= MD_FIN;
                    end
                end
                MD_FIN: begin
                    if (r_f3[1]) begin
                        r_result <= r_negr ? (32'd0 - r_rem) : r_rem;
                    end else begin
                        r_result <= r_negq ? (32'd0 - r_quo) : r_quo;
                    end
                    r_done  <= 1'b1;
                    r_state <= MD_IDLE;
                end
                default: r_state <= MD_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;
endmodule

// ===== sv/rv32im_instruction_step_core.sv =====
// Throughput: one item at a time, set by the fetch/decode/execute sequencer and RAM port.
// Reset: synchronous; pc = 0x80000000, registers zero except x2 = RAM end (valid bits),
// RAM contents undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
// RV32IM instruction step core
// Multicycle RV32IM core around a register file memory and a program RAM.
// ----------------------------------------------------------------------------
`include "rv32im_instruction_step_core_defines.svh"

module rv32im_instruction_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_load_address,
    input  logic [31:0] i_value_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_pc_out,
    output logic [31:0] o_instruction_word,
    output logic [31:0] o_call_number,
    output logic [31:0] o_call_arg0,
    output logic [31:0] o_call_arg1,
    output logic [31:0] o_call_arg2
);
    localparam int AW = rvstep_pkg::RAM_AW;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_DECODE, S_EXEC, S_MD, S_MEM0, S_MEM1, S_MEM2,
        S_CALL0, S_CALL1, S_CALL2, S_DONE
    } t_state;

    typedef enum logic [2:0] {K_ILL, K_DONE, K_MD, K_MEM, K_ECALL} t_kind;

    t_state      r_state;
    logic [31:0] r_ram_base;
    logic [31:0] r_pc;
    logic        r_halted;
    logic        r_ecall_wait;
    logic [1:0]  r_op;
    logic [31:0] r_laddr;
    logic [31:0] r_value;
    logic [31:0] r_instr;
    logic [4:0]  r_rd;
    logic [31:0] r_moff;
    logic [2:0]  r_mf3;
    logic        r_mstore;
    logic [31:0] r_sdata;
    logic [31:0] r_w0;
    logic [2:0]  r_st_status;
    logic [31:0] r_st_word;
    logic [31:0] r_st_cn;
    logic [31:0] r_st_c0;
    logic [31:0] r_st_c1;
    logic [31:0] r_st_c2;
    logic        r_out_valid;
    logic [2:0]  r_o_status;
    logic [31:0] r_o_pc;
    logic [31:0] r_o_word;
    logic [31:0] r_o_cn;
    logic [31:0] r_o_c0;
    logic [31:0] r_o_c1;
    logic [31:0] r_o_c2;

    logic [31:0] n_ram_end;
    logic [31:0] n_pc_off;
    logic [31:0] n_ld_off;
    logic        n_ld_ok;
    logic [AW-1:0] n_ram_addr;
    logic        n_ram_we;
    logic [3:0]  n_ram_be;
    logic [31:0] n_ram_wdata;
    logic [31:0] ram_rdata;
    logic [4:0]  n_rf_ra;
    logic [4:0]  n_rf_rb;
    logic        n_rf_we;
    logic [4:0]  n_rf_wa;
    logic [31:0] n_rf_wd;
    logic [31:0] rs1;
    logic [31:0] rs2;
    rvstep_pkg::t_md_req n_md_req;
    logic        md_done;
    logic [31:0] md_result;

    logic [6:0]  e_opc;
    logic [2:0]  e_f3;
    logic [6:0]  e_f7;
    logic [31:0] e_imm_i;
    logic [31:0] e_imm_s;
    logic [31:0] e_imm_b;
    logic [31:0] e_imm_j;
    logic [31:0] e_pc4;
    logic [31:0] e_alu_b;
    logic        e_alt;
    logic [31:0] e_alu;
    logic        e_take;
    logic [31:0] e_maddr;
    logic [31:0] e_moff;
    logic [2:0]  e_nbytes;
    logic        e_mok;
    t_kind       e_kind;
    logic        e_we;
    logic [31:0] e_wd;
    logic [31:0] e_next;
    logic [63:0] n_sh_data;
    logic [7:0]  n_sh_be;
    logic [63:0] n_ld_win;
    logic [31:0] n_ld_val;

    assign n_ram_end = r_ram_base + rvstep_pkg::RAM_BYTES;
    assign n_pc_off  = r_pc - r_ram_base;
    assign n_ld_off  = {r_laddr[31:2], 2'b00} - r_ram_base;
    assign n_ld_ok   = rvstep_pkg::f_in_ram(n_ld_off, 3'd4);

    rvstep_ram u_ram (
        .i_clk   (i_clk),
        .i_addr  (n_ram_addr),
        .i_we    (n_ram_we),
        .i_be    (n_ram_be),
        .i_wdata (n_ram_wdata),
        .o_rdata (ram_rdata)
    );

    rvstep_rf u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ram_end (n_ram_end),
        .i_clr_sp  (i_cfg_we),
        .i_raddr_a (n_rf_ra),
        .i_raddr_b (n_rf_rb),
        .o_rdata_a (rs1),
        .o_rdata_b (rs2),
        .i_we      (n_rf_we),
        .i_waddr   (n_rf_wa),
        .i_wdata   (n_rf_wd)
    );

    rvstep_md u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (n_md_req),
        .o_done   (md_done),
        .o_result (md_result)
    );

    function automatic logic [31:0] f_alu(input logic [2:0] f3, input logic alt,
                                          input logic [31:0] a, input logic [31:0] b);
        case (f3)
            3'd0:    return alt ? (a - b) : (a + b);
            3'd1:    return a << b[4:0];
            3'd2:    return {31'd0, $signed(a) < $signed(b)};
            3'd3:    return {31'd0, a < b};
            3'd4:    return a ^ b;
            3'd5:    return alt ? 32'($signed(a) >>> b[4:0]) : (a >> b[4:0]);
            3'd6:    return a | b;
            default: return a & b;
        endcase
    endfunction

    // decode and execute
    always_comb begin
        e_opc    = r_instr[6:0];
        e_f3     = r_instr[14:12];
        e_f7     = r_instr[31:25];
        e_imm_i  = {{20{r_instr[31]}}, r_instr[31:20]};
        e_imm_s  = {{20{r_instr[31]}}, r_instr[31:25], r_instr[11:7]};
        e_imm_b  = {{20{r_instr[31]}}, r_instr[7], r_instr[30:25], r_instr[11:8], 1'b0};
        e_imm_j  = {{12{r_instr[31]}}, r_instr[19:12], r_instr[20], r_instr[30:21], 1'b0};
        e_pc4    = r_pc + 32'd4;
        e_alu_b  = (e_opc == rvstep_pkg::OPC_OP) ? rs2 : e_imm_i;
        e_alt    = (e_f7 == rvstep_pkg::F7_ALT) &&
                   ((e_opc == rvstep_pkg::OPC_OP) || (e_f3 == 3'd5));
        e_alu    = f_alu(e_f3, e_alt, rs1, e_alu_b);
        e_maddr  = rs1 + ((e_opc == rvstep_pkg::OPC_STORE) ? e_imm_s : e_imm_i);
        e_moff   = e_maddr - r_ram_base;
        e_nbytes = e_f3[1] ? 3'd4 : (e_f3[0] ? 3'd2 : 3'd1);
        e_mok    = rvstep_pkg::f_in_ram(e_moff, e_nbytes);
        e_kind   = K_DONE;
        e_we     = 1'b0;
        e_wd     = e_pc4;
        e_next   = e_pc4;
        e_take   = 1'b0;
        case (e_opc)
            rvstep_pkg::OPC_LUI: begin
                e_we = 1'b1;
                e_wd = {r_instr[31:12], 12'd0};
            end
            rvstep_pkg::OPC_AUIPC: begin
                e_we = 1'b1;
                e_wd = r_pc + {r_instr[31:12], 12'd0};
            end
            rvstep_pkg::OPC_JAL: begin
                e_we   = 1'b1;
                e_next = r_pc + e_imm_j;
            end
            rvstep_pkg::OPC_JALR: begin
                if (e_f3 != 3'd0) begin
                    e_kind = K_ILL;
                end else begin
                    e_we   = 1'b1;
                    e_next = (rs1 + e_imm_i) & ~32'd1;
                end
            end
            rvstep_pkg::OPC_BRANCH: begin
                case (e_f3)
                    3'd0:    e_take = rs1 == rs2;
                    3'd1:    e_take = rs1 != rs2;
                    3'd4:    e_take = $signed(rs1) < $signed(rs2);
                    3'd5:    e_take = $signed(rs1) >= $signed(rs2);
                    3'd6:    e_take = rs1 < rs2;
                    3'd7:    e_take = rs1 >= rs2;
                    default: e_kind = K_ILL;
                endcase
                if (e_take) begin
                    e_next = r_pc + e_imm_b;
                end
            end
            rvstep_pkg::OPC_LOAD: begin
                if ((e_f3 == 3'd3) || (e_f3 == 3'd6) || (e_f3 == 3'd7)) begin
                    e_kind = K_ILL;
                end else begin
                    e_kind = K_MEM;
                    e_we   = !e_mok;
                    e_wd   = 32'd0;
                end
            end
            rvstep_pkg::OPC_STORE: begin
                e_kind = (e_f3 > 3'd2) ? K_ILL : K_MEM;
            end
            rvstep_pkg::OPC_OP: begin
                if (e_f7 == rvstep_pkg::F7_MULDIV) begin
                    e_kind = K_MD;
                end else if ((e_f7 == 7'd0) ||
                             ((e_f7 == rvstep_pkg::F7_ALT) && ((e_f3 == 3'd0) || (e_f3 == 3'd5)))) begin
                    e_we = 1'b1;
                    e_wd = e_alu;
                end else begin
                    e_kind = K_ILL;
                end
            end
            rvstep_pkg::OPC_OPIMM: begin
                if (((e_f3 == 3'd1) && (e_f7 != 7'd0)) ||
                    ((e_f3 == 3'd5) && (e_f7 != 7'd0) && (e_f7 != rvstep_pkg::F7_ALT))) begin
                    e_kind = K_ILL;
                end else begin
                    e_we = 1'b1;
                    e_wd = e_alu;
                end
            end
            rvstep_pkg::OPC_SYSTEM: begin
                e_kind = (r_instr == rvstep_pkg::ECALL_WORD) ? K_ECALL : K_ILL;
            end
            default: e_kind = K_ILL;
        endcase
        if (e_kind == K_ILL) begin
            e_we = 1'b0;
        end
    end

    // memory lane alignment
    always_comb begin
        n_sh_data = {32'd0, r_sdata} << {r_moff[1:0], 3'b000};
        n_sh_be   = {4'd0, (r_mf3[1] ? 4'b1111 : (r_mf3[0] ? 4'b0011 : 4'b0001))}
                    << r_moff[1:0];
        n_ld_win  = {ram_rdata, r_w0} >> {r_moff[1:0], 3'b000};
        case (r_mf3)
            3'd0:    n_ld_val = {{24{n_ld_win[7]}}, n_ld_win[7:0]};
            3'd1:    n_ld_val = {{16{n_ld_win[15]}}, n_ld_win[15:0]};
            3'd4:    n_ld_val = {24'd0, n_ld_win[7:0]};
            3'd5:    n_ld_val = {16'd0, n_ld_win[15:0]};
            default: n_ld_val = n_ld_win[31:0];
        endcase
    end

    // memory, register file and unit ports
    always_comb begin
        n_ram_addr  = n_pc_off[AW+1:2];
        n_ram_we    = 1'b0;
        n_ram_be    = 4'b1111;
        n_ram_wdata = r_value;
        n_rf_ra     = ram_rdata[19:15];
        n_rf_rb     = ram_rdata[24:20];
        n_rf_we     = 1'b0;
        n_rf_wa     = r_rd;
        n_rf_wd     = e_wd;
        n_md_req.start  = (r_state == S_EXEC) && (e_kind == K_MD);
        n_md_req.funct3 = e_f3;
        n_md_req.a      = rs1;
        n_md_req.b      = rs2;
        case (r_state)
            S_DISP: begin
                if (r_op == rvstep_pkg::OPS_LOAD) begin
                    n_ram_addr = n_ld_off[AW+1:2];
                    n_ram_we   = n_ld_ok;
                end
                if ((r_op == rvstep_pkg::OPS_RET) && !r_halted && r_ecall_wait) begin
                    n_rf_we = 1'b1;
                    n_rf_wa = rvstep_pkg::REG_A0;
                    n_rf_wd = r_value;
                end
            end
            S_EXEC: n_rf_we = e_we;
            S_MD: begin
                n_rf_we = md_done;
                n_rf_wd = md_result;
            end
            S_MEM0: begin
                n_ram_addr  = r_moff[AW+1:2];
                n_ram_we    = r_mstore;
                n_ram_be    = n_sh_be[3:0];
                n_ram_wdata = n_sh_data[31:0];
            end
            S_MEM1: begin
                n_ram_addr  = r_moff[AW+1:2] + AW'(1);
                n_ram_we    = r_mstore && (n_sh_be[7:4] != 4'd0);
                n_ram_be    = n_sh_be[7:4];
                n_ram_wdata = n_sh_data[63:32];
            end
            S_MEM2: begin
                n_rf_we = !r_mstore;
                n_rf_wd = n_ld_val;
            end
            S_CALL0: begin
                n_rf_ra = rvstep_pkg::REG_A7;
                n_rf_rb = rvstep_pkg::REG_A0;
            end
            S_CALL1: begin
                n_rf_ra = rvstep_pkg::REG_A1;
                n_rf_rb = rvstep_pkg::REG_A2;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ram_base   <= rvstep_pkg::RESET_BASE;
            r_pc         <= rvstep_pkg::RESET_BASE;
            r_halted     <= 1'b0;
            r_ecall_wait <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ram_base <= i_cfg_wdata;
                r_pc       <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_laddr <= i_load_address;
                        r_value <= i_value_in;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_st_status <= rvstep_pkg::ST_EXEC;
                    r_st_word   <= 32'd0;
                    r_st_cn     <= 32'd0;
                    r_st_c0     <= 32'd0;
                    r_st_c1     <= 32'd0;
                    r_st_c2     <= 32'd0;
                    r_state     <= S_DONE;
                    case (r_op)
                        rvstep_pkg::OPS_LOAD: r_st_status <= rvstep_pkg::ST_LOADED;
                        rvstep_pkg::OPS_EXEC: begin
                            if (r_halted) begin
                                r_st_status <= rvstep_pkg::ST_HALTED;
                            end else if (r_ecall_wait) begin
                                r_state <= S_CALL0;
                            end else if (r_pc[1:0] != 2'd0) begin
                                r_st_status <= rvstep_pkg::ST_MISALIGN;
                                r_halted    <= 1'b1;
                            end else if (!rvstep_pkg::f_in_ram(n_pc_off, 3'd4)) begin
                                r_st_status <= rvstep_pkg::ST_FETCH;
                                r_halted    <= 1'b1;
                            end else begin
                                r_state <= S_DECODE;
                            end
                        end
                        rvstep_pkg::OPS_RET: begin
                            if (r_halted) begin
                                r_st_status <= rvstep_pkg::ST_HALTED;
                            end else begin
                                r_ecall_wait <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DECODE: begin
                    r_instr   <= ram_rdata;
                    r_st_word <= ram_rdata;
                    r_rd      <= ram_rdata[11:7];
                    r_state   <= S_EXEC;
                end
                S_EXEC: begin
                    r_moff   <= e_moff;
                    r_mf3    <= e_f3;
                    r_mstore <= (e_opc == rvstep_pkg::OPC_STORE);
                    r_sdata  <= rs2;
                    if (e_kind != K_ILL) begin
                        r_pc <= e_next;
                    end
                    case (e_kind)
                        K_ILL: begin
                            r_st_status <= rvstep_pkg::ST_ILLEGAL;
                            r_halted    <= 1'b1;
                            r_state     <= S_DONE;
                        end
                        K_MD:    r_state <= S_MD;
                        K_MEM:   r_state <= e_mok ? S_MEM0 : S_DONE;
                        K_ECALL: begin
                            r_ecall_wait <= 1'b1;
                            r_state      <= S_CALL0;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MD: begin
                    if (md_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_MEM0: r_state <= S_MEM1;
                S_MEM1: begin
                    r_w0    <= ram_rdata;
                    r_state <= r_mstore ? S_DONE : S_MEM2;
                end
                S_MEM2:  r_state <= S_DONE;
                S_CALL0: r_state <= S_CALL1;
                S_CALL1: begin
                    r_st_cn <= rs1;
                    r_st_c0 <= rs2;
                    r_state <= S_CALL2;
                end
                S_CALL2: begin
                    r_st_c1     <= rs1;
                    r_st_c2     <= rs2;
                    r_st_status <= rvstep_pkg::ST_ECALL;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_st_status;
                        r_o_pc      <= r_pc;
                        r_o_word    <= r_st_word;
                        r_o_cn      <= r_st_cn;
                        r_o_c0      <= r_st_c0;
                        r_o_c1      <= r_st_c1;
                        r_o_c2      <= r_st_c2;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_pc_out           = r_o_pc;
    assign o_instruction_word = r_o_word;
    assign o_call_number      = r_o_cn;
    assign o_call_arg0        = r_o_c0;
    assign o_call_arg1        = r_o_c1;
    assign o_call_arg2        = r_o_c2;

    `RVSTEP_ASSERT_NEXT(a_halt_sticky, i_rst_n && r_halted, r_halted)
    `RVSTEP_ASSERT_IMPL(a_halt_report, o_out_valid && (o_status == rvstep_pkg::ST_HALTED), r_halted)
    `RVSTEP_ASSERT_IMPL(a_md_only_exec, md_done, r_state == S_MD)
endmodule
